@@ design/ptsc_pkg.sv @@
package ptsc_pkg;

   // Saturation bound of the compressed difference, the knee and the slowdown range
   localparam int unsigned STEP_LIMIT = 64;
   localparam int unsigned KNEE       = 4;
   localparam int unsigned SLOW_RANGE = 4;

   localparam logic signed [7:0] MOTION_LIMIT = 8'(STEP_LIMIT);

   localparam logic [19:0] SPAN_SINGLE = 20'h80000;
   localparam logic [19:0] SPAN_DOUBLE = 20'h40000;

   // 2^32 - 2^15: remainder of this plus WRAP_GUARD is congruent to 2^32
   localparam logic [31:0] BIAS_DIVIDEND  = 32'hFFFF_8000;
   localparam logic [20:0] WRAP_GUARD     = 21'h08000;
   localparam logic [31:0] RECIP_DIVIDEND = 32'h0010_0000;

   // ceil(2^20 / z); exact floor division for 16 bit magnitudes. Zoom 0 passes through.
   localparam logic [20:0] ZOOM_RECIP [16] = '{
      21'd1048576, 21'd1048576, 21'd524288, 21'd349526,
      21'd262144,  21'd209716,  21'd174763, 21'd149797,
      21'd131072,  21'd116509,  21'd104858, 21'd95326,
      21'd87382,   21'd80660,   21'd74899,  21'd69906
   };

   typedef enum logic [2:0] {
      REG_INTEGRATION_ENABLE,
      REG_SINGLE_PAGE_MODE,
      REG_ZOOM_X,
      REG_ZOOM_Y,
      REG_VRAM_OFFSET,
      REG_BYTES_PER_LINE,
      REG_HALVED_X_MODE
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] host_x;
      logic signed [15:0] host_y;
      logic [15:0]        guest_x;
      logic [15:0]        guest_y;
      logic               guest_valid;
   } req_payload_type;

   typedef struct packed {
      logic signed [7:0] motion_x;
      logic signed [7:0] motion_y;
      logic              controlled;
   } rsp_payload_type;

endpackage

@@ design/pointer_tracking_step_controller.sv @@
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     req_data  (req_payload_type)
// rsp       out        rsp_valid / rsp_ready     rsp_data  (rsp_payload_type)
// csr       in         csr_wr_en                 csr_index, csr_wr_data
//
// Ten register stages: one transaction per cycle while neither rsp_ready nor a geometry recompute stalls the input.
// A write to single_page_mode, vram_offset or bytes_per_line starts the geometry
// recompute on the shared serial divider: 4 divisions in sequence, with req_ready
// low while it runs. Other registers take effect at once.
// Reset (synchronous) restores register defaults and empties the pipeline.
// A stage holds only while its successor holds, so bubbles close up under a stall.
module pointer_tracking_step_controller
   import ptsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [2:0]      csr_index,
   input  logic [18:0]     csr_wr_data
);

   localparam int unsigned NUM_STAGES = 10;
   localparam logic [5:0]  DIV_STEPS  = 6'd32;

   typedef enum logic [2:0] {
      CFG_IDLE,
      CFG_LINE,
      CFG_HEIGHT,
      CFG_BIAS,
      CFG_RECIP
   } cfg_state_type;

   // configuration registers
   logic        integration_enable_ff;
   logic        single_page_mode_ff;
   logic [3:0]  zoom_x_ff;
   logic [3:0]  zoom_y_ff;
   logic [18:0] vram_offset_ff;
   logic [12:0] bytes_per_line_ff;
   logic        halved_x_mode_ff;

   // geometry sequencer and divider
   cfg_state_type cfg_state_ff;
   logic [5:0]    div_cnt_ff;
   logic [19:0]   div_rem_ff;
   logic [31:0]   div_quo_ff;
   logic [19:0]   div_den_ff;
   logic [20:0]   div_trial;
   logic          div_ge;
   logic [19:0]   div_rem_in;
   logic [31:0]   div_quo_in;
   logic [31:0]   div_num_sel;
   logic [19:0]   div_den_sel;
   logic [18:0]   line_off_ff;
   logic [19:0]   height_ff;
   logic [20:0]   wrap_base_ff;
   logic [15:0]   recip_ff;
   logic          geometry_write;
   logic          busy;
   logic          wrap_on;

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] stage_en;

   // stage 1
   logic        s1_active_ff, s1_sign_x_ff, s1_sign_y_ff;
   logic [15:0] s1_mag_x_ff, s1_mag_y_ff, s1_gx_ff, s1_gy_ff;
   logic [15:0] s1_mag_x_in, s1_mag_y_in;
   // stage 2
   logic        s2_active_ff, s2_sign_x_ff, s2_sign_y_ff;
   logic [35:0] s2_prod_x_ff, s2_prod_y_ff;
   logic [15:0] s2_gx_ff, s2_gy_ff;
   logic [36:0] s2_mul_x, s2_mul_y;
   // stage 3
   logic        s3_active_ff, s3_sign_x_ff;
   logic [16:0] s3_hx_ff, s3_hy_ff;
   logic [15:0] s3_half_x_ff;
   logic [19:0] s3_u_ff;
   logic [15:0] s3_gx_ff, s3_gy_ff;
   logic [15:0] s3_quo_x, s3_quo_y;
   logic [19:0] s3_zoom_mul;
   logic [20:0] s3_pos_sum, s3_neg_diff, s3_neg_wrap;
   logic [19:0] s3_u_in;
   // stage 4
   logic        s4_active_ff;
   logic [16:0] s4_x_ff, s4_hy_ff;
   logic [35:0] s4_prod_y_ff;
   logic [19:0] s4_u_ff;
   logic [15:0] s4_gx_ff, s4_gy_ff;
   logic [14:0] s4_half;
   logic [16:0] s4_x_in;
   // stage 5
   logic        s5_active_ff;
   logic [16:0] s5_x_ff, s5_hy_ff;
   logic [19:0] s5_take_ff, s5_u_ff;
   logic [15:0] s5_gx_ff, s5_gy_ff;
   logic [35:0] s5_mul;
   // stage 6
   logic        s6_active_ff;
   logic [16:0] s6_x_ff;
   logic [20:0] s6_y_ff;
   logic [15:0] s6_gx_ff, s6_gy_ff;
   logic [19:0] s6_rem, s6_mod;
   logic [20:0] s6_y_in;
   // stage 7
   logic        s7_active_ff;
   logic [20:0] s7_dx_ff, s7_dy_ff;
   // stage 8
   logic        s8_active_ff, s8_neg_x_ff, s8_neg_y_ff;
   logic [19:0] s8_mag_x_ff, s8_mag_y_ff;
   logic [20:0] s8_abs_x, s8_abs_y;
   // stage 9
   logic        s9_active_ff, s9_neg_x_ff, s9_neg_y_ff;
   logic [6:0]  s9_c_x_ff, s9_c_y_ff;
   logic [19:0] s9_knee_x, s9_knee_y;
   logic [6:0]  s9_c_x_in, s9_c_y_in;
   // stage 10
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic [6:0]      s10_c_x, s10_c_y;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         integration_enable_ff <= 1'b0;
         single_page_mode_ff   <= 1'b1;
         zoom_x_ff             <= 4'd1;
         zoom_y_ff             <= 4'd1;
         vram_offset_ff        <= '0;
         bytes_per_line_ff     <= '0;
         halved_x_mode_ff      <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_INTEGRATION_ENABLE: integration_enable_ff <= csr_wr_data[0];
            REG_SINGLE_PAGE_MODE:   single_page_mode_ff   <= csr_wr_data[0];
            REG_ZOOM_X:             zoom_x_ff             <= csr_wr_data[3:0];
            REG_ZOOM_Y:             zoom_y_ff             <= csr_wr_data[3:0];
            REG_VRAM_OFFSET:        vram_offset_ff        <= csr_wr_data;
            REG_BYTES_PER_LINE:     bytes_per_line_ff     <= csr_wr_data[12:0];
            REG_HALVED_X_MODE:      halved_x_mode_ff      <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   assign geometry_write = csr_wr_en && (csr_index == REG_SINGLE_PAGE_MODE ||
                                         csr_index == REG_VRAM_OFFSET ||
                                         csr_index == REG_BYTES_PER_LINE);
   assign busy    = cfg_state_ff != CFG_IDLE;
   assign wrap_on = !halved_x_mode_ff && bytes_per_line_ff != '0;

   // ------------------------------------------------------- geometry divider
   // line offset, height, 2^32 bias mod height, then 2^20 / height for the
   // per-transaction reciprocal reduction
   always_comb begin
      div_trial  = {div_rem_ff, div_quo_ff[31]};
      div_ge     = div_trial >= {1'b0, div_den_ff};
      div_rem_in = div_ge ? 20'(div_trial - {1'b0, div_den_ff}) : div_trial[19:0];
      div_quo_in = {div_quo_ff[30:0], div_ge};
      case (cfg_state_ff)
         CFG_LINE: begin
            div_num_sel = {13'd0, vram_offset_ff};
            div_den_sel = {7'd0, bytes_per_line_ff};
         end
         CFG_HEIGHT: begin
            div_num_sel = {12'd0, single_page_mode_ff ? SPAN_SINGLE : SPAN_DOUBLE};
            div_den_sel = {7'd0, bytes_per_line_ff};
         end
         CFG_BIAS: begin
            div_num_sel = BIAS_DIVIDEND;
            div_den_sel = height_ff;
         end
         default: begin
            div_num_sel = RECIP_DIVIDEND;
            div_den_sel = height_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_state_ff <= CFG_IDLE;
         div_cnt_ff   <= '0;
      end else if (geometry_write) begin
         cfg_state_ff <= CFG_LINE;
         div_cnt_ff   <= '0;
      end else if (cfg_state_ff != CFG_IDLE) begin
         if (div_cnt_ff == '0) begin
            div_rem_ff <= '0;
            div_quo_ff <= div_num_sel;
            div_den_ff <= div_den_sel;
            div_cnt_ff <= 6'd1;
         end else begin
            div_rem_ff <= div_rem_in;
            div_quo_ff <= div_quo_in;
            if (div_cnt_ff == DIV_STEPS) begin
               div_cnt_ff <= '0;
               unique case (cfg_state_ff)
                  CFG_LINE: begin
                     line_off_ff  <= div_quo_in[18:0];
                     cfg_state_ff <= CFG_HEIGHT;
                  end
                  CFG_HEIGHT: begin
                     height_ff    <= div_quo_in[19:0];
                     cfg_state_ff <= CFG_BIAS;
                  end
                  CFG_BIAS: begin
                     wrap_base_ff <= {1'b0, div_rem_in} + WRAP_GUARD + {2'b0, line_off_ff};
                     cfg_state_ff <= CFG_RECIP;
                  end
                  CFG_RECIP: begin
                     recip_ff     <= div_quo_in[15:0];
                     cfg_state_ff <= CFG_IDLE;
                  end
                  default: cfg_state_ff <= CFG_IDLE;
               endcase
            end else begin
               div_cnt_ff <= div_cnt_ff + 6'd1;
            end
         end
      end
   end

   // -------------------------------------------------------- pipeline control
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign req_ready = stage_en[0] && !busy;
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_valid && !busy;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // -------------------------------------------------------------- datapath
   always_comb begin
      // stage 1: magnitudes
      s1_mag_x_in = req_data.host_x[15] ? 16'(-req_data.host_x) : req_data.host_x;
      s1_mag_y_in = req_data.host_y[15] ? 16'(-req_data.host_y) : req_data.host_y;

      // stage 2: zoom division by reciprocal
      s2_mul_x = 37'(s1_mag_x_ff) * 37'(ZOOM_RECIP[zoom_x_ff]);
      s2_mul_y = 37'(s1_mag_y_ff) * 37'(ZOOM_RECIP[zoom_y_ff]);

      // stage 3: signed quotients, halved-mode rescale, y moved to a
      // non-negative value congruent to the 32 bit pattern
      s3_quo_x    = s2_prod_x_ff[35:20];
      s3_quo_y    = s2_prod_y_ff[35:20];
      s3_zoom_mul = 20'(s3_quo_x) * 20'(zoom_x_ff);
      s3_pos_sum  = {5'd0, s3_quo_y} + {2'd0, line_off_ff};
      s3_neg_diff = {2'd0, line_off_ff} - {5'd0, s3_quo_y};
      s3_neg_wrap = wrap_base_ff - {5'd0, s3_quo_y};
      if (!s2_sign_y_ff) begin
         s3_u_in = s3_pos_sum[19:0];
      end else if (s3_neg_diff[20]) begin
         s3_u_in = s3_neg_wrap[19:0];
      end else begin
         s3_u_in = s3_neg_diff[19:0];
      end

      // stage 4: final x
      s4_half = s3_half_x_ff[15:1];
      if (halved_x_mode_ff) begin
         s4_x_in = s3_sign_x_ff ? 17'd0 - {2'b0, s4_half} : {2'b0, s4_half};
      end else begin
         s4_x_in = s3_hx_ff;
      end

      // stage 5: quotient estimate times height
      s5_mul = 36'(s4_prod_y_ff[35:20]) * 36'(height_ff);

      // stage 6: remainder with one correction step
      s6_rem = s5_u_ff - s5_take_ff;
      s6_mod = (s6_rem >= height_ff) ? s6_rem - height_ff : s6_rem;
      s6_y_in = wrap_on ? {1'b0, s6_mod} : {{4{s5_hy_ff[16]}}, s5_hy_ff};

      // stage 8: sign and magnitude of the differences
      s8_abs_x = s7_dx_ff[20] ? 21'd0 - s7_dx_ff : s7_dx_ff;
      s8_abs_y = s7_dy_ff[20] ? 21'd0 - s7_dy_ff : s7_dy_ff;

      // stage 9: compression beyond the knee, then saturation
      s9_knee_x = 20'(KNEE) + ((s8_mag_x_ff - 20'(KNEE)) >> 2);
      s9_knee_y = 20'(KNEE) + ((s8_mag_y_ff - 20'(KNEE)) >> 2);
      if (s8_mag_x_ff <= 20'(KNEE)) begin
         s9_c_x_in = s8_mag_x_ff[6:0];
      end else if (s9_knee_x > 20'(STEP_LIMIT)) begin
         s9_c_x_in = 7'(STEP_LIMIT);
      end else begin
         s9_c_x_in = s9_knee_x[6:0];
      end
      if (s8_mag_y_ff <= 20'(KNEE)) begin
         s9_c_y_in = s8_mag_y_ff[6:0];
      end else if (s9_knee_y > 20'(STEP_LIMIT)) begin
         s9_c_y_in = 7'(STEP_LIMIT);
      end else begin
         s9_c_y_in = s9_knee_y[6:0];
      end

      // stage 10: slowdown to a unit step, negate
      s10_c_x = s9_c_x_ff;
      s10_c_y = s9_c_y_ff;
      if (halved_x_mode_ff && s9_c_x_ff != '0 && s9_c_x_ff <= 7'(SLOW_RANGE)) begin
         s10_c_x = 7'd1;
      end
      if (halved_x_mode_ff && s9_c_y_ff != '0 && s9_c_y_ff <= 7'(SLOW_RANGE)) begin
         s10_c_y = 7'd1;
      end
      rsp_data_in.controlled = s9_active_ff;
      if (!s9_active_ff) begin
         rsp_data_in.motion_x = '0;
         rsp_data_in.motion_y = '0;
      end else begin
         rsp_data_in.motion_x = s9_neg_x_ff ? {1'b0, s10_c_x} : 8'd0 - {1'b0, s10_c_x};
         rsp_data_in.motion_y = s9_neg_y_ff ? {1'b0, s10_c_y} : 8'd0 - {1'b0, s10_c_y};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_active_ff <= req_data.guest_valid && integration_enable_ff;
         s1_sign_x_ff <= req_data.host_x[15];
         s1_sign_y_ff <= req_data.host_y[15];
         s1_mag_x_ff  <= s1_mag_x_in;
         s1_mag_y_ff  <= s1_mag_y_in;
         s1_gx_ff     <= req_data.guest_x;
         s1_gy_ff     <= req_data.guest_y;
      end
      if (stage_en[1]) begin
         s2_active_ff <= s1_active_ff;
         s2_sign_x_ff <= s1_sign_x_ff;
         s2_sign_y_ff <= s1_sign_y_ff;
         s2_prod_x_ff <= s2_mul_x[35:0];
         s2_prod_y_ff <= s2_mul_y[35:0];
         s2_gx_ff     <= s1_gx_ff;
         s2_gy_ff     <= s1_gy_ff;
      end
      if (stage_en[2]) begin
         s3_active_ff <= s2_active_ff;
         s3_sign_x_ff <= s2_sign_x_ff;
         s3_hx_ff     <= s2_sign_x_ff ? 17'd0 - {1'b0, s3_quo_x} : {1'b0, s3_quo_x};
         s3_hy_ff     <= s2_sign_y_ff ? 17'd0 - {1'b0, s3_quo_y} : {1'b0, s3_quo_y};
         s3_half_x_ff <= s3_zoom_mul[15:0];
         s3_u_ff      <= s3_u_in;
         s3_gx_ff     <= s2_gx_ff;
         s3_gy_ff     <= s2_gy_ff;
      end
      if (stage_en[3]) begin
         s4_active_ff <= s3_active_ff;
         s4_x_ff      <= s4_x_in;
         s4_hy_ff     <= s3_hy_ff;
         s4_prod_y_ff <= 36'(s3_u_ff) * 36'(recip_ff);
         s4_u_ff      <= s3_u_ff;
         s4_gx_ff     <= s3_gx_ff;
         s4_gy_ff     <= s3_gy_ff;
      end
      if (stage_en[4]) begin
         s5_active_ff <= s4_active_ff;
         s5_x_ff      <= s4_x_ff;
         s5_hy_ff     <= s4_hy_ff;
         s5_take_ff   <= s5_mul[19:0];
         s5_u_ff      <= s4_u_ff;
         s5_gx_ff     <= s4_gx_ff;
         s5_gy_ff     <= s4_gy_ff;
      end
      if (stage_en[5]) begin
         s6_active_ff <= s5_active_ff;
         s6_x_ff      <= s5_x_ff;
         s6_y_ff      <= s6_y_in;
         s6_gx_ff     <= s5_gx_ff;
         s6_gy_ff     <= s5_gy_ff;
      end
      if (stage_en[6]) begin
         s7_active_ff <= s6_active_ff;
         s7_dx_ff     <= {{4{s6_x_ff[16]}}, s6_x_ff} - {5'd0, s6_gx_ff};
         s7_dy_ff     <= s6_y_ff - {5'd0, s6_gy_ff};
      end
      if (stage_en[7]) begin
         s8_active_ff <= s7_active_ff;
         s8_neg_x_ff  <= s7_dx_ff[20];
         s8_neg_y_ff  <= s7_dy_ff[20];
         s8_mag_x_ff  <= s8_abs_x[19:0];
         s8_mag_y_ff  <= s8_abs_y[19:0];
      end
      if (stage_en[8]) begin
         s9_active_ff <= s8_active_ff;
         s9_neg_x_ff  <= s8_neg_x_ff;
         s9_neg_y_ff  <= s8_neg_y_ff;
         s9_c_x_ff    <= s9_c_x_in;
         s9_c_y_ff    <= s9_c_y_in;
      end
      if (stage_en[9]) begin
         rsp_data_ff  <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_geometry_write_holds_input: assert property (@(posedge clock) disable iff (reset)
      geometry_write |=> !req_ready)
      else $error("transaction accepted during geometry recompute");

   a_inactive_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.controlled |->
         rsp_data.motion_x == '0 && rsp_data.motion_y == '0)
      else $error("uncontrolled result carries motion");

   a_motion_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.motion_x <= MOTION_LIMIT && rsp_data.motion_x >= -MOTION_LIMIT &&
                    rsp_data.motion_y <= MOTION_LIMIT && rsp_data.motion_y >= -MOTION_LIMIT)
      else $error("motion beyond step limit");

   a_divider_count_bounded: assert property (@(posedge clock) disable iff (reset)
      !busy |=> div_cnt_ff == '0 || $past(geometry_write))
      else $error("divider running while sequencer idle");
`endif

endmodule

@@ test/ptsc_motion_monitor.sv @@
module ptsc_motion_monitor
   import ptsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [2:0]      csr_index,
   input  logic [18:0]     csr_wr_data,
   output int              mismatch_count,
   output int              outstanding
);

   // shadow copy of the register file
   bit          track_enable;
   bit          wide_span;
   int          zoom_h;
   int          zoom_v;
   int unsigned page_offset;
   int unsigned line_pitch;
   bit          halved_x;

   rsp_payload_type motion_q[$];
   rsp_payload_type want;
   int              fails = 0;

   function automatic int squash_step(int d);
      int k;
      k = int'(KNEE);
      if (d < -k) begin
         d = -k + (d + k) / 4;
         return (d < -int'(STEP_LIMIT)) ? -int'(STEP_LIMIT) : d;
      end
      if (d > k) begin
         d = k + (d - k) / 4;
         return (d > int'(STEP_LIMIT)) ? int'(STEP_LIMIT) : d;
      end
      return d;
   endfunction

   function automatic int nudge_step(int d, int range);
      if (d >= -range && d <= range) begin
         if (d < 0) return -1;
         if (d > 0) return 1;
      end
      return d;
   endfunction

   function automatic rsp_payload_type predict_motion(req_payload_type t);
      rsp_payload_type p;
      int              hx;
      int              hy;
      int              gx;
      int              gy;
      int              range;
      int              dx;
      int              dy;
      int unsigned     span;
      int unsigned     height;
      int unsigned     yu;
      p     = '0;
      hx    = int'(t.host_x);
      hy    = int'(t.host_y);
      gx    = int'({16'b0, t.guest_x});
      gy    = int'({16'b0, t.guest_y});
      range = 0;
      if (!t.guest_valid || !track_enable) return p;
      if (zoom_h != 0) hx = hx / zoom_h;
      if (zoom_v != 0) hy = hy / zoom_v;
      if (halved_x) begin
         hx    = hx * zoom_h;
         hx    = hx / 2;
         range = int'(SLOW_RANGE);
      end else if (line_pitch != 0) begin
         span   = wide_span ? int'(SPAN_SINGLE) : int'(SPAN_DOUBLE);
         height = span / line_pitch;
         // negative y wraps as its 32-bit pattern
         yu = $unsigned(hy) + page_offset / line_pitch;
         yu = yu % height;
         hy = int'(yu);
      end
      dx = nudge_step(squash_step(hx - gx), range);
      dy = nudge_step(squash_step(hy - gy), range);
      p.motion_x   = 8'(-dx);
      p.motion_y   = 8'(-dy);
      p.controlled = 1'b1;
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         track_enable = 1'b0;
         wide_span    = 1'b1;
         zoom_h       = 1;
         zoom_v       = 1;
         page_offset  = 0;
         line_pitch   = 0;
         halved_x     = 1'b0;
         motion_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               REG_INTEGRATION_ENABLE: track_enable = csr_wr_data[0];
               REG_SINGLE_PAGE_MODE:   wide_span    = csr_wr_data[0];
               REG_ZOOM_X:             zoom_h       = int'(csr_wr_data[3:0]);
               REG_ZOOM_Y:             zoom_v       = int'(csr_wr_data[3:0]);
               REG_VRAM_OFFSET:        page_offset  = {13'd0, csr_wr_data};
               REG_BYTES_PER_LINE:     line_pitch   = {19'd0, csr_wr_data[12:0]};
               REG_HALVED_X_MODE:      halved_x     = csr_wr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (motion_q.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected result mx=%0d my=%0d ctl=%0b", $time,
                           rsp_data.motion_x, rsp_data.motion_y, rsp_data.controlled);
            end else begin
               want = motion_q.pop_front();
               if (rsp_data.motion_x !== want.motion_x ||
                   rsp_data.motion_y !== want.motion_y ||
                   rsp_data.controlled !== want.controlled) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: mismatch exp mx=%0d my=%0d ctl=%0b got mx=%0d my=%0d ctl=%0b",
                              $time, want.motion_x, want.motion_y, want.controlled,
                              rsp_data.motion_x, rsp_data.motion_y, rsp_data.controlled);
               end
            end
         end
         if (req_valid && req_ready)
            motion_q.insert(motion_q.size(), predict_motion(req_data));
      end
      mismatch_count <= fails;
      outstanding    <= motion_q.size();
   end

endmodule

@@ test/pointer_tracking_step_controller_tb.sv @@
module pointer_tracking_step_controller_tb;
   import ptsc_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 120;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_wr_en;
   logic [2:0]      csr_index;
   logic [18:0]     csr_wr_data;

   int mismatch_count;
   int outstanding;
   bit hold_req  = 1'b0;
   bit hold_done = 1'b0;
   bit steady    = 1'b0;

   pointer_tracking_step_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   ptsc_motion_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // result side: random back-pressure, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   function automatic req_payload_type pointer_req(int hx, int hy, int gx, int gy, bit v);
      req_payload_type t;
      t.host_x      = 16'(hx);
      t.host_y      = 16'(hy);
      t.guest_x     = 16'(gx);
      t.guest_y     = 16'(gy);
      t.guest_valid = v;
      return t;
   endfunction

   function automatic req_payload_type random_pointer_req();
      int kind;
      int gx;
      int gy;
      bit v;
      kind = $urandom_range(0, 9);
      v    = ($urandom_range(0, 9) != 0);
      if (kind < 3)
         return pointer_req($urandom, $urandom, $urandom, $urandom, v);
      if (kind < 6)
         return pointer_req(int'($urandom_range(0, 600)) - 300,
                            int'($urandom_range(0, 600)) - 300,
                            $urandom_range(0, 300), $urandom_range(0, 300), v);
      // host close to guest so the knees and slowdown band get hit
      gx = $urandom_range(0, 2000);
      gy = $urandom_range(0, 2000);
      return pointer_req(gx + int'($urandom_range(0, 40)) - 20,
                         gy + int'($urandom_range(0, 40)) - 20, gx, gy, v);
   endfunction

   task automatic send_pointer(req_payload_type t);
      if (!steady && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [18:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // geometry writes keep the input stalled while the divider runs
      repeat (2) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic set_config(bit en, bit spm, int zx, int zy, int off, int bpl, bit hv);
      write_reg(REG_INTEGRATION_ENABLE, 19'(en));
      write_reg(REG_SINGLE_PAGE_MODE, 19'(spm));
      write_reg(REG_ZOOM_X, 19'(zx));
      write_reg(REG_ZOOM_Y, 19'(zy));
      write_reg(REG_VRAM_OFFSET, 19'(off));
      write_reg(REG_BYTES_PER_LINE, 19'(bpl));
      write_reg(REG_HALVED_X_MODE, 19'(hv));
   endtask

   function automatic int pick_zoom();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 15;
         2:       return 1;
         default: return $urandom_range(0, 15);
      endcase
   endfunction

   function automatic int pick_pitch();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 4096;
         2:       return 8191;
         3:       return 1;
         4:       return ($urandom_range(0, 1) != 0) ? 640 : 1024;
         default: return $urandom_range(1, 8191);
      endcase
   endfunction

   function automatic int pick_offset();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 'h7FFFF;
         default: return $urandom_range(0, 'h7FFFF);
      endcase
   endfunction

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tracking off after reset
      send_pointer(pointer_req(100, -100, 0, 0, 1'b1));
      send_pointer(pointer_req(-7, 7, 3, 3, 1'b0));
      drain();

      write_reg(REG_INTEGRATION_ENABLE, 19'd1);
      send_pointer(pointer_req(-32768, 32767, 0, 65535, 1'b1));
      send_pointer(pointer_req(32767, -32768, 65535, 0, 1'b1));
      send_pointer(pointer_req(0, 0, 0, 0, 1'b1));
      send_pointer(pointer_req(5, -5, 0, 0, 1'b1));
      send_pointer(pointer_req(4, -4, 0, 0, 1'b1));
      send_pointer(pointer_req(9, -9, 0, 0, 1'b1));
      send_pointer(pointer_req(300, -300, 0, 0, 1'b1));
      send_pointer(pointer_req(0, 0, 3, 0, 1'b0));
      drain();

      // halved x, no vertical zoom
      set_config(1'b1, 1'b1, 3, 0, 0, 0, 1'b1);
      send_pointer(pointer_req(7, 1, 0, 0, 1'b1));
      send_pointer(pointer_req(-7, -3, 0, 0, 1'b1));
      send_pointer(pointer_req(20, 2, 0, 5, 1'b1));
      send_pointer(pointer_req(32767, -32768, 0, 0, 1'b1));
      drain();
      write_reg(REG_ZOOM_X, 19'd0);
      send_pointer(pointer_req(1000, 5, 3, 3, 1'b1));
      drain();

      // vertical wrap, half span, largest offset
      set_config(1'b1, 1'b0, 15, 15, 'h7FFFF, 4096, 1'b0);
      send_pointer(pointer_req(-1, -32768, 0, 0, 1'b1));
      send_pointer(pointer_req(32767, 100, 0, 60, 1'b1));
      drain();
      write_reg(REG_BYTES_PER_LINE, 19'd8191);
      write_reg(REG_ZOOM_Y, 19'd1);
      send_pointer(pointer_req(-5, -1, 0, 40, 1'b1));
      send_pointer(pointer_req(50, 32767, 10, 0, 1'b1));
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         set_config($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), pick_zoom(),
                    pick_zoom(), pick_offset(), pick_pitch(), $urandom_range(0, 2) == 0);
         if (ph == 3) hold_req = 1'b1;
         steady = (ph == 5);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 7 && i == PHASE_ITEMS / 2) drain();
            send_pointer(random_pointer_req());
         end
         drain();
      end
      steady = 1'b0;

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
